FILE: design/btsc_pkg.sv
// ----------------------------------------------------------------------------
// btsc_pkg : shared types and codes of the ball tracking steer controller
// Item kinds, drive modes, register indexes and the configuration record.
// ----------------------------------------------------------------------------
package btsc_pkg;

   // request selector codes
   localparam logic [1:0] FUNC_BALL  = 2'd0;
   localparam logic [1:0] FUNC_EMPTY = 2'd1;
   localparam logic [1:0] FUNC_OBST  = 2'd2;

   // command kinds passed from the front to the back
   localparam logic [1:0] KIND_FRAME = 2'd0;
   localparam logic [1:0] KIND_EMPTY = 2'd1;
   localparam logic [1:0] KIND_OBST  = 2'd2;

   // drive modes
   localparam logic [1:0] MODE_TRACK   = 2'd0;
   localparam logic [1:0] MODE_SEARCH  = 2'd1;
   localparam logic [1:0] MODE_BLOCKED = 2'd2;

   // register indexes
   localparam logic [2:0] REG_LOST_LIMIT   = 3'd0;
   localparam logic [2:0] REG_CENTER_X     = 3'd1;
   localparam logic [2:0] REG_STEER_GAIN   = 3'd2;
   localparam logic [2:0] REG_CRUISE_SPEED = 3'd3;
   localparam logic [2:0] REG_SEARCH_TURN  = 3'd4;
   localparam logic [2:0] REG_FILTER_W     = 3'd5;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 13;

   // full weight of the smoothing filter
   localparam logic [8:0] FULL_WEIGHT = 9'd256;

   typedef struct packed {
      logic [5:0]  lost_limit;
      logic [9:0]  center_x;
      logic [7:0]  steer_gain;
      logic [11:0] cruise_speed;
      logic [12:0] search_turn;
      logic [8:0]  filter_old_weight;
   } btsc_cfg_type;

   typedef struct packed {
      logic [1:0] kind;
      logic       obstacle;
   } btsc_cmd_type;

endpackage

FILE: design/ball_tracking_steer_controller_unit.sv
// ----------------------------------------------------------------------------
// ball_tracking_steer_controller_unit : ball tracking steer controller
// Picks the largest ball of each frame, smooths its column and drives speed
// and turn commands, with search turning when lost or blocked.
// ----------------------------------------------------------------------------
//   channel  | direction | handshake          | contents
//   req_     | in        | tvalid/tready      | detection, empty frame, obstacle
//   rsp_     | out       | tvalid/tready      | speed, turn rate, drive mode
//   csr_     | in        | we (no wait)       | six control registers
//
// A detection is taken each cycle while the command queue has room.
// Each frame end runs the back sequencer in order: queue pop, two filter
// multiplies, one steering multiply, rounding with response load. An empty
// frame skips the filter multiplies; an obstacle update is only popped. Reset
// clears control state, not payload registers, and loads register defaults.
// A stalled response holds the back; the queue fills and req_tready falls.
// ----------------------------------------------------------------------------
module ball_tracking_steer_controller_unit import btsc_pkg::*; #(
   parameter int COORD_BITS  = 10,
   parameter int FRAC_BITS   = 8,
   parameter int QUEUE_DEPTH = 4
) (
   input  logic clock,
   input  logic reset,
   // request channel
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // tdata: ball_x, ball_radius, obstacle_on, zero fill
   input  logic [((COORD_BITS + 11 + 7) / 8) * 8 - 1:0] req_tdata,
   // tuser: func
   input  logic [1:0]                             req_tuser,
   input  logic                                   req_tlast,
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // tdata: linear_speed, angular_rate, zero fill
   output logic [31:0] rsp_tdata,
   // tuser: drive_mode
   output logic [1:0]  rsp_tuser,
   // configuration port
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam int QW = COORD_BITS + 3;

   btsc_cfg_type          cfg_ff, cfg_in;
   logic                  accept;
   logic                  push;
   btsc_cmd_type          push_cmd;
   logic [COORD_BITS-1:0] push_x;
   logic                  q_full, q_empty, q_pop;
   logic [QW-1:0]         q_data;
   btsc_cmd_type          q_cmd;
   logic [COORD_BITS-1:0] q_x;
   logic [11:0]           rsp_speed;
   logic [12:0]           rsp_rate;

   // decode register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_LOST_LIMIT:   cfg_in.lost_limit        = csr_wdata[5:0];
            REG_CENTER_X:     cfg_in.center_x          = csr_wdata[9:0];
            REG_STEER_GAIN:   cfg_in.steer_gain        = csr_wdata[7:0];
            REG_CRUISE_SPEED: cfg_in.cruise_speed      = csr_wdata[11:0];
            REG_SEARCH_TURN:  cfg_in.search_turn       = csr_wdata[12:0];
            REG_FILTER_W:     cfg_in.filter_old_weight = csr_wdata[8:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.lost_limit        <= 6'd40;
         cfg_ff.center_x          <= 10'd320;
         cfg_ff.steer_gain        <= 8'd5;
         cfg_ff.cruise_speed      <= 12'd400;
         cfg_ff.search_turn       <= 13'd800;
         cfg_ff.filter_old_weight <= 9'd51;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;

   btsc_front #(
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .func        (req_tuser),
      .ball_x      (req_tdata[COORD_BITS-1:0]),
      .ball_radius (req_tdata[COORD_BITS+9:COORD_BITS]),
      .last_ball   (req_tlast),
      .obstacle_on (req_tdata[COORD_BITS+10]),
      .push        (push),
      .push_cmd    (push_cmd),
      .push_x      (push_x)
   );

   btsc_queue #(
      .WIDTH (QW),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({push_cmd, push_x}),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_data),
      .empty     (q_empty)
   );

   assign q_cmd = q_data[QW-1:COORD_BITS];
   assign q_x   = q_data[COORD_BITS-1:0];

   btsc_back #(
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_empty   (q_empty),
      .q_cmd     (q_cmd),
      .q_x       (q_x),
      .q_pop     (q_pop),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_speed (rsp_speed),
      .rsp_rate  (rsp_rate),
      .rsp_mode  (rsp_tuser)
   );

   assign rsp_tdata = {7'd0, rsp_rate, rsp_speed};

endmodule

FILE: design/btsc_queue.sv
// ----------------------------------------------------------------------------
// btsc_queue : short command queue between front and back
// Register-based first-in first-out store with full and empty flags.
// ----------------------------------------------------------------------------
module btsc_queue #(
   parameter int WIDTH = 13,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);
   localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(DEPTH - 1);

   logic [WIDTH-1:0]    store_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                do_push, do_pop;

   assign full     = (count_ff == CNT_BITS'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = store_ff[rd_ptr_ff];

   // advance pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // write the entry
   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: design/btsc_front.sv
// ----------------------------------------------------------------------------
// btsc_front : request intake and per-frame ball selection
// Accepts items, keeps the largest ball of the running frame and issues
// frame-end, empty-frame and obstacle commands to the queue.
// ----------------------------------------------------------------------------
module btsc_front import btsc_pkg::*; #(
   parameter int COORD_BITS = 10
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [1:0]            func,
   input  logic [COORD_BITS-1:0] ball_x,
   input  logic [9:0]            ball_radius,
   input  logic                  last_ball,
   input  logic                  obstacle_on,
   output logic                  push,
   output btsc_cmd_type          push_cmd,
   output logic [COORD_BITS-1:0] push_x
);

   logic [COORD_BITS-1:0] best_x_ff, best_x_in;
   logic [9:0]            best_radius_ff, best_radius_in;
   logic                  in_frame_ff, in_frame_in;
   logic                  take_new;
   logic [COORD_BITS-1:0] cand_x;

   // first ball of a frame, or a strictly larger one, replaces the kept ball
   assign take_new = !in_frame_ff || (ball_radius > best_radius_ff);
   assign cand_x   = take_new ? ball_x : best_x_ff;

   // classify the item
   always_comb begin
      best_x_in         = best_x_ff;
      best_radius_in    = best_radius_ff;
      in_frame_in       = in_frame_ff;
      push              = 1'b0;
      push_cmd.kind     = KIND_FRAME;
      push_cmd.obstacle = obstacle_on;
      push_x            = cand_x;
      if (accept) begin
         unique case (func)
            FUNC_BALL: begin
               if (take_new) begin
                  best_x_in      = ball_x;
                  best_radius_in = ball_radius;
               end
               in_frame_in = !last_ball;
               push        = last_ball;
            end
            FUNC_EMPTY: begin
               in_frame_in   = 1'b0;
               push          = 1'b1;
               push_cmd.kind = KIND_EMPTY;
            end
            FUNC_OBST: begin
               push          = 1'b1;
               push_cmd.kind = KIND_OBST;
            end
            default: begin
               push = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_x_ff      <= '0;
         best_radius_ff <= '0;
         in_frame_ff    <= 1'b0;
      end else begin
         best_x_ff      <= best_x_in;
         best_radius_ff <= best_radius_in;
         in_frame_ff    <= in_frame_in;
      end
   end

endmodule

FILE: design/btsc_back.sv
// ----------------------------------------------------------------------------
// btsc_back : filter, lost counter and steering sequencer
// Takes commands from the queue, smooths the ball column, tracks empty
// frames and loads the response register.
// ----------------------------------------------------------------------------
module btsc_back import btsc_pkg::*; #(
   parameter int COORD_BITS = 10,
   parameter int FRAC_BITS  = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  btsc_cfg_type          cfg,
   input  logic                  q_empty,
   input  btsc_cmd_type          q_cmd,
   input  logic [COORD_BITS-1:0] q_x,
   output logic                  q_pop,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [11:0]           rsp_speed,
   output logic [12:0]           rsp_rate,
   output logic [1:0]            rsp_mode
);

   localparam int FX_BITS = COORD_BITS + FRAC_BITS;
   localparam int PRODW   = FX_BITS + 10;
   localparam int CW      = (COORD_BITS > 10) ? COORD_BITS : 10;
   localparam int DW      = CW + FRAC_BITS + 1;
   localparam int PW      = DW + 9;
   localparam int RW      = PW - FRAC_BITS;
   localparam logic signed [RW-1:0] SAT_HI = RW'(4095);
   localparam logic signed [RW-1:0] SAT_LO = RW'(-4096);
   localparam logic [PW-1:0] HALF = PW'(1) << (FRAC_BITS - 1);
   localparam logic [PRODW-1:0] ROUND = PRODW'(128);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_FILT1 = 3'd1;
   localparam logic [2:0] S_FILT2 = 3'd2;
   localparam logic [2:0] S_STEER = 3'd3;
   localparam logic [2:0] S_EMIT  = 3'd4;

   logic [2:0]             state_ff, state_in;
   logic [5:0]             lost_ff, lost_in;
   logic [FX_BITS-1:0]     fx_ff, fx_in;
   logic                   obst_ff, obst_in;
   logic [COORD_BITS-1:0]  bx_ff, bx_in;
   logic [PRODW-1:0]       prod_ff, prod_in;
   logic signed [PW-1:0]   p_ff, p_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [11:0]            rsp_speed_ff, rsp_speed_in;
   logic [12:0]            rsp_rate_ff, rsp_rate_in;
   logic [1:0]             rsp_mode_ff, rsp_mode_in;

   logic [8:0]             w;
   logic [8:0]             w_new;
   logic [6:0]             lost_inc;
   logic [PRODW-1:0]       acc;
   logic signed [DW-1:0]   diff;
   logic [PW-1:0]          rnd;
   logic signed [RW-1:0]   r;
   logic [12:0]            r_sat;
   logic                   out_free;
   logic                   searching;

   // saturate the old-value weight
   assign w     = (cfg.filter_old_weight > FULL_WEIGHT) ? FULL_WEIGHT : cfg.filter_old_weight;
   assign w_new = FULL_WEIGHT - w;

   assign lost_inc = {1'b0, lost_ff} + 7'd1;
   assign acc      = prod_ff + (PRODW'(w) * PRODW'(fx_ff)) + ROUND;
   assign diff     = signed'(DW'(fx_ff) - DW'({cfg.center_x, {FRAC_BITS{1'b0}}}));

   // round to nearest, ties upward, then clamp
   assign rnd = p_ff + HALF;
   assign r   = signed'(rnd[PW-1:FRAC_BITS]);
   always_comb begin
      if (r > SAT_HI) begin
         r_sat = 13'(SAT_HI);
      end else if (r < SAT_LO) begin
         r_sat = 13'(SAT_LO);
      end else begin
         r_sat = r[12:0];
      end
   end

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign searching = (lost_ff == cfg.lost_limit) || obst_ff;
   assign q_pop     = (state_ff == S_IDLE) && !q_empty;

   // sequence one command
   always_comb begin
      state_in     = state_ff;
      lost_in      = lost_ff;
      fx_in        = fx_ff;
      obst_in      = obst_ff;
      bx_in        = bx_ff;
      prod_in      = prod_ff;
      p_in         = p_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_speed_in = rsp_speed_ff;
      rsp_rate_in  = rsp_rate_ff;
      rsp_mode_in  = rsp_mode_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (!q_empty) begin
               unique case (q_cmd.kind)
                  KIND_FRAME: begin
                     bx_in    = q_x;
                     state_in = S_FILT1;
                  end
                  KIND_EMPTY: begin
                     lost_in  = (lost_inc >= {1'b0, cfg.lost_limit}) ?
                                cfg.lost_limit : lost_inc[5:0];
                     state_in = S_STEER;
                  end
                  KIND_OBST: begin
                     obst_in = q_cmd.obstacle;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_FILT1: begin
            prod_in  = PRODW'(w_new) * PRODW'({bx_ff, {FRAC_BITS{1'b0}}});
            state_in = S_FILT2;
         end
         S_FILT2: begin
            fx_in    = acc[FX_BITS+7:8];
            lost_in  = '0;
            state_in = S_STEER;
         end
         S_STEER: begin
            p_in     = signed'(PW'(cfg.steer_gain)) * PW'(diff);
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (searching) begin
                  rsp_speed_in = '0;
                  rsp_rate_in  = cfg.search_turn;
                  rsp_mode_in  = obst_ff ? MODE_BLOCKED : MODE_SEARCH;
               end else begin
                  rsp_speed_in = cfg.cruise_speed;
                  rsp_rate_in  = r_sat;
                  rsp_mode_in  = MODE_TRACK;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         lost_ff      <= '0;
         fx_ff        <= '0;
         obst_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         lost_ff      <= lost_in;
         fx_ff        <= fx_in;
         obst_ff      <= obst_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      bx_ff        <= bx_in;
      prod_ff      <= prod_in;
      p_ff         <= p_in;
      rsp_speed_ff <= rsp_speed_in;
      rsp_rate_ff  <= rsp_rate_in;
      rsp_mode_ff  <= rsp_mode_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_speed = rsp_speed_ff;
   assign rsp_rate  = rsp_rate_ff;
   assign rsp_mode  = rsp_mode_ff;

endmodule

FILE: bench/tb.sv
// ----------------------------------------------------------------------------
// tb : self-checking bench for the ball tracking steer controller unit
// Drives detections, empty frames and obstacle updates in bursts, stalls the
// response side and checks every speed, turn and mode command against an
// in-bench prediction of frame selection, filtering and steering.
// ----------------------------------------------------------------------------
module tb import btsc_pkg::*;;

   localparam int COORD     = 10;
   localparam int FRAC      = 8;
   localparam int REQ_W     = ((COORD + 11 + 7) / 8) * 8;
   localparam int HOLD_OFF  = 24;
   localparam int MAX_CYCLE = 400000;

   // selector value the block ignores
   localparam logic [1:0] FUNC_IGNORED = 2'd3;

   typedef struct {
      logic [11:0] speed;
      logic [12:0] turn;
      logic [1:0]  mode;
   } drive_cmd_type;

   // -------------------------------------------------------------------------
   // Expected command tracker: mirrors frame state and holds due commands
   // -------------------------------------------------------------------------
   class steer_cmd_tracker;
      btsc_cfg_type  regs;
      logic [5:0]    lost_count;
      logic [17:0]   filt_x;
      logic          obstacle;
      logic [9:0]    best_x;
      logic [9:0]    best_rad;
      logic          in_frame;
      drive_cmd_type cmds_due[$];
      int            errors;
      int            checked;

      function new();
         regs.lost_limit        = 6'd40;
         regs.center_x          = 10'd320;
         regs.steer_gain        = 8'd5;
         regs.cruise_speed      = 12'd400;
         regs.search_turn       = 13'd800;
         regs.filter_old_weight = 9'd51;
         lost_count = '0;
         filt_x     = '0;
         obstacle   = 1'b0;
         best_x     = '0;
         best_rad   = '0;
         in_frame   = 1'b0;
         errors     = 0;
         checked    = 0;
      endfunction

      function void set_reg(logic [2:0] idx, logic [12:0] val);
         case (idx)
            REG_LOST_LIMIT:   regs.lost_limit        = val[5:0];
            REG_CENTER_X:     regs.center_x          = val[9:0];
            REG_STEER_GAIN:   regs.steer_gain        = val[7:0];
            REG_CRUISE_SPEED: regs.cruise_speed      = val[11:0];
            REG_SEARCH_TURN:  regs.search_turn       = val[12:0];
            REG_FILTER_W:     regs.filter_old_weight = val[8:0];
            default: ;
         endcase
      endfunction

      // speed, turn and mode from the current tracking state
      function drive_cmd_type frame_command();
         drive_cmd_type c;
         longint        diff;
         longint        rate;
         if (lost_count == regs.lost_limit || obstacle) begin
            c.speed = '0;
            c.turn  = regs.search_turn;
            c.mode  = obstacle ? MODE_BLOCKED : MODE_SEARCH;
         end else begin
            diff = longint'(filt_x) - (longint'(regs.center_x) << FRAC);
            rate = (longint'(regs.steer_gain) * diff + (longint'(1) << (FRAC - 1))) >>> FRAC;
            if (rate > 4095) rate = 4095;
            else if (rate < -4096) rate = -4096;
            c.speed = regs.cruise_speed;
            c.turn  = 13'(rate);
            c.mode  = MODE_TRACK;
         end
         return c;
      endfunction

      // advance state on one accepted item and queue any command it causes
      function void take_item(logic [1:0] func, logic [9:0] x, logic [9:0] rad,
                              logic last, logic obst);
         longint w;
         longint acc;
         int     nxt;
         case (func)
            FUNC_OBST: obstacle = obst;
            FUNC_EMPTY: begin
               in_frame = 1'b0;
               nxt = int'(lost_count) + 1;
               lost_count = (nxt >= int'(regs.lost_limit)) ? regs.lost_limit : 6'(nxt);
               cmds_due.insert(cmds_due.size(), frame_command());
            end
            FUNC_BALL: begin
               if (!in_frame || rad > best_rad) begin
                  best_x   = x;
                  best_rad = rad;
               end
               in_frame = 1'b1;
               if (last) begin
                  w = (regs.filter_old_weight > FULL_WEIGHT) ? 256 : regs.filter_old_weight;
                  acc = (256 - w) * (longint'(best_x) << FRAC) + w * longint'(filt_x) + 128;
                  filt_x = 18'(acc >> 8);
                  lost_count = '0;
                  in_frame   = 1'b0;
                  cmds_due.insert(cmds_due.size(), frame_command());
               end
            end
            default: ;
         endcase
      endfunction

      // compare one accepted command with the oldest one due
      function void match_cmd(logic [11:0] speed, logic [12:0] turn, logic [1:0] mode);
         drive_cmd_type e;
         checked++;
         if (cmds_due.size() == 0) begin
            errors++;
            $display("%0t: command with none due: speed %0d turn %0d mode %0d",
                     $time, speed, $signed(turn), mode);
            return;
         end
         e = cmds_due.pop_front();
         if (speed !== e.speed) begin
            errors++;
            $display("%0t: linear_speed expected %0d actual %0d", $time, e.speed, speed);
         end
         if (turn !== e.turn) begin
            errors++;
            $display("%0t: angular_rate expected %0d actual %0d",
                     $time, $signed(e.turn), $signed(turn));
         end
         if (mode !== e.mode) begin
            errors++;
            $display("%0t: drive_mode expected %0d actual %0d", $time, e.mode, mode);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   logic             req_tvalid;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata;
   logic [1:0]       req_tuser;
   logic             req_tlast;
   logic             rsp_tvalid;
   logic             rsp_tready;
   logic [31:0]      rsp_tdata;
   logic [1:0]       rsp_tuser;
   logic                      csr_we;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wdata;

   steer_cmd_tracker tracker;
   int items_sent;
   int burst_left;
   int stall_left;
   int stall_mode;
   int cycles;

   ball_tracking_steer_controller_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // watch both channels; commands are checked before the new item is noted
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready)
            tracker.match_cmd(rsp_tdata[11:0], rsp_tdata[24:12], rsp_tuser);
         if (req_tvalid && req_tready)
            tracker.take_item(req_tuser, req_tdata[9:0], req_tdata[19:10],
                              req_tlast, req_tdata[20]);
      end
   end

   // response stalls: stretches of always ready, random, mostly ready, long hold
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_left = $urandom_range(1, 40);
         stall_mode = $urandom_range(0, 3);
      end
      stall_left--;
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= 1'($urandom_range(0, 1));
         2: rsp_tready <= ($urandom_range(0, 3) != 0);
         default: rsp_tready <= (stall_left == 0);
      endcase
   end

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > MAX_CYCLE) begin
         $display("FAIL ball_tracking_steer_controller_unit");
         $finish;
      end
   end

   // end a burst now and then and hold the sender for a random gap
   task automatic pace();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                  : $urandom_range(0, 10);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic send_item(input logic [1:0] func, input logic [9:0] x,
                            input logic [9:0] rad, input logic last, input logic obst);
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tlast  <= last;
      req_tdata  <= REQ_W'({obst, rad, x});
      do @(posedge clock); while (!req_tready);
      if (func != FUNC_IGNORED) items_sent++;
      pace();
   endtask

   // hold the sender until no command is due, optionally letting the back settle
   task automatic drain(input bit hold);
      req_tvalid <= 1'b0;
      do @(posedge clock); while (tracker.cmds_due.size() != 0);
      if (hold) repeat (HOLD_OFF) @(posedge clock);
   endtask

   task automatic load_settings(input btsc_cfg_type s);
      logic [2:0]  idx [6];
      logic [12:0] val [6];
      idx = '{REG_LOST_LIMIT, REG_CENTER_X, REG_STEER_GAIN,
              REG_CRUISE_SPEED, REG_SEARCH_TURN, REG_FILTER_W};
      val = '{13'(s.lost_limit), 13'(s.center_x), 13'(s.steer_gain),
              13'(s.cruise_speed), s.search_turn, 13'(s.filter_old_weight)};
      csr_we <= 1'b1;
      for (int i = 0; i < 6; i++) begin
         csr_index <= idx[i];
         csr_wdata <= val[i];
         @(posedge clock);
         tracker.set_reg(idx[i], val[i]);
      end
      csr_we <= 1'b0;
   endtask

   function automatic btsc_cfg_type random_settings();
      btsc_cfg_type s;
      s.lost_limit        = 6'($urandom_range(1, 6));
      s.center_x          = 10'($urandom_range(0, 1023));
      s.steer_gain        = 8'($urandom_range(0, 255));
      s.cruise_speed      = 12'($urandom_range(0, 4095));
      s.search_turn       = 13'($urandom_range(0, 8191));
      s.filter_old_weight = 9'($urandom_range(0, 300));
      return s;
   endfunction

   // mostly whole frames with random content, plus empties, obstacles and noise
   task automatic random_traffic(input int count);
      int stop_at;
      int pick;
      int nb;
      bit narrow;
      stop_at = items_sent + count;
      while (items_sent < stop_at) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            nb = $urandom_range(1, 5);
            narrow = ($urandom_range(0, 2) == 0);
            for (int k = 0; k < nb; k++)
               send_item(FUNC_BALL, 10'($urandom_range(0, 1023)),
                         narrow ? 10'($urandom_range(0, 3)) : 10'($urandom_range(0, 1023)),
                         k == nb - 1, 1'($urandom_range(0, 1)));
         end else if (pick < 85) begin
            send_item(FUNC_EMPTY, 10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         end else if (pick < 93) begin
            send_item(FUNC_OBST, 10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)),
                      1'($urandom_range(0, 1)), ($urandom_range(0, 2) == 0));
         end else if (pick < 97) begin
            // partial frame cut short by an empty frame
            nb = $urandom_range(1, 3);
            for (int k = 0; k < nb; k++)
               send_item(FUNC_BALL, 10'($urandom_range(0, 1023)),
                         10'($urandom_range(0, 1023)), 1'b0, 1'($urandom_range(0, 1)));
            send_item(FUNC_EMPTY, 10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         end else begin
            send_item(FUNC_IGNORED, 10'($urandom_range(0, 1023)),
                      10'($urandom_range(0, 1023)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
         end
         if ($urandom_range(0, 99) == 0) drain(1'b0);
      end
   endtask

   initial begin
      btsc_cfg_type s;
      int phases;
      tracker    = new();
      items_sent = 0;
      burst_left = 0;
      stall_left = 0;
      stall_mode = 0;
      cycles     = 0;
      phases     = 1;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= FUNC_BALL;
      req_tlast  <= 1'b0;
      rsp_tready <= 1'b0;
      csr_we     <= 1'b0;
      csr_index  <= REG_LOST_LIMIT;
      csr_wdata  <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: defaults after reset
      send_item(FUNC_OBST, 10'd1023, 10'd1023, 1'b1, 1'b0);
      send_item(FUNC_IGNORED, 10'd1023, 10'd1023, 1'b1, 1'b1);
      // equal radii: the first ball wins
      send_item(FUNC_BALL, 10'd1023, 10'd1023, 1'b0, 1'b1);
      send_item(FUNC_BALL, 10'd0, 10'd1023, 1'b1, 1'b0);
      // all radii zero
      send_item(FUNC_BALL, 10'd5, 10'd0, 1'b0, 1'b0);
      send_item(FUNC_BALL, 10'd700, 10'd0, 1'b1, 1'b0);
      send_item(FUNC_BALL, 10'd0, 10'd0, 1'b1, 1'b0);
      // empty frame while tracking keeps the held column
      send_item(FUNC_EMPTY, 10'd0, 10'd0, 1'b0, 1'b0);
      // empty frame inside a partial frame
      send_item(FUNC_BALL, 10'd100, 10'd3, 1'b0, 1'b0);
      send_item(FUNC_EMPTY, 10'd1023, 10'd1023, 1'b1, 1'b1);
      // obstacle blocks both ball and empty frames
      send_item(FUNC_OBST, 10'd0, 10'd0, 1'b0, 1'b1);
      send_item(FUNC_BALL, 10'd500, 10'd10, 1'b1, 1'b0);
      send_item(FUNC_EMPTY, 10'd0, 10'd0, 1'b0, 1'b0);
      send_item(FUNC_OBST, 10'd0, 10'd0, 1'b0, 1'b0);
      // largest radius in the middle of the frame
      send_item(FUNC_BALL, 10'd300, 10'd1, 1'b0, 1'b0);
      send_item(FUNC_BALL, 10'd400, 10'd9, 1'b0, 1'b0);
      send_item(FUNC_BALL, 10'd200, 10'd9, 1'b1, 1'b0);
      drain(1'b1);

      // extremes: shortest lost limit, lost and blocked together
      s = '{6'd1, 10'd0, 8'd255, 12'd4095, 13'h1000, 9'd0};
      load_settings(s);
      send_item(FUNC_EMPTY, 10'd0, 10'd0, 1'b0, 1'b0);
      send_item(FUNC_OBST, 10'd0, 10'd0, 1'b0, 1'b1);
      send_item(FUNC_EMPTY, 10'd0, 10'd0, 1'b0, 1'b0);
      send_item(FUNC_OBST, 10'd0, 10'd0, 1'b0, 1'b0);
      send_item(FUNC_BALL, 10'd1023, 10'd1023, 1'b1, 1'b0);
      random_traffic(85);
      drain(1'b1);
      phases++;

      s = '{6'd63, 10'd1023, 8'd255, 12'd0, 13'd4095, 9'd256};
      load_settings(s);
      random_traffic(60);
      drain(1'b1);
      phases++;

      // lost limit zero and a filter weight above full scale
      s = '{6'd0, 10'd512, 8'd0, 12'd1234, 13'h1fff, 9'd511};
      load_settings(s);
      random_traffic(40);
      drain(1'b1);
      phases++;

      repeat (4) begin
         load_settings(random_settings());
         random_traffic(90);
         drain(1'b1);
         phases++;
      end

      $display("Sent %0d items over %0d register settings; checked %0d commands.",
               items_sent, phases, tracker.checked);
      if (tracker.errors == 0)
         $display("PASS ball_tracking_steer_controller_unit");
      else
         $display("FAIL ball_tracking_steer_controller_unit");
      $finish;
   end

endmodule
